>>> rtl/cfgm_pkg.sv
// Package for the clip fade gain mixer: widths, register indexes, FSM states
// and the request/response structs of the shared divider.
// No dependencies; every other file depends on it.
package cfgm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int FRAME_W  = 28;
	localparam int CHCNT_W  = 4;
	localparam int CFG_W    = 28;
	localparam int CFG_IDX_W = 3;

	localparam int FACT_W   = 17;
	localparam int QUO_W    = 16;
	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int DIV_CYCLES = QUO_W / DIV_BITS_PER_CYCLE;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	localparam int MAG_W    = 16;
	localparam int P1_W     = 33;
	localparam int P2_W     = MAG_W + GAIN_W;
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 17;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int SCALED_W = 20;
	localparam int SUM_W    = 21;

	localparam logic [FACT_W-1:0] Q16_ONE = 17'h10000;
	localparam logic signed [SUM_W-1:0] SAT_MAX = 21'sd32767;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -21'sd32768;

	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_FRAMES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_FRAMES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAMES     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_IN_GO,
		ST_DIV_IN,
		ST_DIV_OUT_GO,
		ST_DIV_OUT,
		ST_MUL_FADE,
		ST_MUL_GAIN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [FRAME_W-1:0] rem0;
		logic [FRAME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/cfgm_if.sv
// Stream channels of the clip fade gain mixer: input word and result word.
// Depends on cfgm_pkg for the field widths.
interface cfgm_in_if;
	logic valid;
	logic ready;
	logic signed [cfgm_pkg::SAMPLE_W-1:0] source_sample;
	logic signed [cfgm_pkg::SAMPLE_W-1:0] mix_sample;

	modport source (output valid, output source_sample, output mix_sample, input ready);
	modport sink (input valid, input source_sample, input mix_sample, output ready);
endinterface

interface cfgm_out_if;
	logic valid;
	logic ready;
	logic signed [cfgm_pkg::SAMPLE_W-1:0] mixed_sample;
	logic clip_done;

	modport source (output valid, output mixed_sample, output clip_done, input ready);
	modport sink (input valid, input mixed_sample, input clip_done, output ready);
endinterface

>>> rtl/cfgm_divider.sv
// Iterative restoring divider, two quotient bits per cycle, 16-bit quotient.
// Expects rem0 < divisor; depends on cfgm_pkg.
module cfgm_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  cfgm_pkg::div_req_t  req,
	output cfgm_pkg::div_rsp_t  rsp
);
	import cfgm_pkg::*;

	logic [FRAME_W-1:0]   rem_q;
	logic [FRAME_W-1:0]   dvs_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FRAME_W-1:0]   rem_d;
	logic [QUO_W-1:0]     quo_d;

	always_comb begin
		logic [FRAME_W:0] t;
		logic             ge;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
			t  = {rem_d, 1'b0};
			ge = (t >= {1'b0, dvs_q});
			if (ge) begin
				t = t - {1'b0, dvs_q};
			end
			rem_d = t[FRAME_W-1:0];
			quo_d = {quo_d[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= DIV_CNT_W'(DIV_CYCLES);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign rsp.done     = (cnt_q == '0);
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/clip_fade_gain_mixer_unit.sv
// Clip fade gain mixer: adds one clip source sample, scaled by a Q4.12 gain and
// linear Q1.16 fade-in/fade-out factors, onto a mix sample with int16 saturation.
// Each word runs two 16-bit fade divisions on the shared two-bits-per-cycle
// divider (a load state, the iterations and a finish state each), four passes
// through the shared 32x17 multiplier, an add/saturate state and the output
// register load. Input is taken only while the sequencer is idle, so a new
// word is not accepted before the last one is in the output register;
// a finished result waits in the output register and the next word may be
// accepted meanwhile, while the load cycle holds until that register is free.
// Depends on cfgm_pkg, cfgm_if, cfgm_divider.
module clip_fade_gain_mixer_unit #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cfgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfgm_pkg::CFG_W-1:0]     cfg_data,
	cfgm_in_if.sink                       sample_in,
	cfgm_out_if.source                    sample_out
);
	import cfgm_pkg::*;

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHE_W = 5;
	localparam logic [CHE_W-1:0] MAX_CH = CHE_W'(MAX_CHANNELS);

	// configuration
	logic [GAIN_W-1:0]  gain_q;
	logic [FRAME_W-1:0] fin_len_q;
	logic [FRAME_W-1:0] fout_len_q;
	logic [FRAME_W-1:0] clip_len_q;
	logic [CHCNT_W-1:0] chan_cnt_q;

	// counters and sequencer
	state_t             state_q, state_d;
	logic [FRAME_W-1:0] frame_q;
	logic [CH_W-1:0]    ch_q;

	// per-word operands
	logic [FRAME_W-1:0]        f_q;
	logic                      fin_en_q, fo_one_q, fo_zero_q, neg_q, done_q;
	logic [MAG_W-1:0]          mag_q;
	logic signed [SAMPLE_W-1:0] mix_q;
	logic [FACT_W-1:0]         fin_q, fout_q;
	logic [P1_W-1:0]           p1_q;
	logic [P2_W-1:0]           p2_q;
	logic [MUL_A_W-1:0]        acc_q;
	logic [SCALED_W-1:0]       scaled_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                      res_done_q;
	logic                      ov_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               in_acc;
	logic               out_free;
	logic [FRAME_W-1:0] len_eff;
	logic [FRAME_W-1:0] fo_start;
	logic [CHE_W-1:0]   chans_eff;
	logic               last_chan;
	logic               done_now;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [MUL_P_W-1:0] hi_sum;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [SUM_W-1:0] sc_w;
	logic signed [SAMPLE_W-1:0] sat_w;

	cfgm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_acc   = sample_in.valid && sample_in.ready;
	assign out_free = !ov_q || sample_out.ready;

	// frame and channel bookkeeping for the word at the input
	always_comb begin
		len_eff = (clip_len_q == '0) ? FRAME_W'(1) : clip_len_q;
		fo_start = (len_eff > fout_len_q) ? len_eff - fout_len_q : '0;
		if (chan_cnt_q == '0) begin
			chans_eff = CHE_W'(1);
		end else if (CHE_W'(chan_cnt_q) > MAX_CH) begin
			chans_eff = MAX_CH;
		end else begin
			chans_eff = CHE_W'(chan_cnt_q);
		end
		last_chan = (CHE_W'(ch_q) >= chans_eff - 1'b1);
		done_now  = last_chan && (frame_q == len_eff - 1'b1);
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_MUL_FADE: begin
				mul_a = MUL_A_W'(fin_q);
				mul_b = fout_q;
			end
			ST_MUL_GAIN: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(gain_q);
			end
			ST_MUL_LO: begin
				mul_a = p2_q;
				mul_b = MUL_B_W'(p1_q[15:0]);
			end
			ST_MUL_HI: begin
				mul_a = p2_q;
				mul_b = p1_q[P1_W-1:16];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
		hi_sum = mul_p + MUL_P_W'(acc_q);
	end

	// sign, add, saturate
	always_comb begin
		sc_w  = $signed({1'b0, scaled_q});
		sum_w = neg_q ? SUM_W'(mix_q) - sc_w : SUM_W'(mix_q) + sc_w;
		if (sum_w > SAT_MAX) begin
			sat_w = SAMPLE_W'(SAT_MAX);
		end else if (sum_w < SAT_MIN) begin
			sat_w = SAMPLE_W'(SAT_MIN);
		end else begin
			sat_w = sum_w[SAMPLE_W-1:0];
		end
	end

	// next state and divider requests
	always_comb begin
		state_d = state_q;
		div_req.start   = 1'b0;
		div_req.rem0    = f_q;
		div_req.divisor = fin_len_q;
		sample_in.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (sample_in.valid) begin
					state_d = ST_DIV_IN_GO;
				end
			end
			ST_DIV_IN_GO: begin
				div_req.start = 1'b1;
				state_d = ST_DIV_IN;
			end
			ST_DIV_IN: begin
				if (div_rsp.done) begin
					state_d = ST_DIV_OUT_GO;
				end
			end
			ST_DIV_OUT_GO: begin
				div_req.start   = 1'b1;
				div_req.rem0    = len_eff - f_q;
				div_req.divisor = fout_len_q;
				state_d = ST_DIV_OUT;
			end
			ST_DIV_OUT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL_FADE;
				end
			end
			ST_MUL_FADE: state_d = ST_MUL_GAIN;
			ST_MUL_GAIN: state_d = ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_SUM;
			ST_SUM:      state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_W'(4096);
			fin_len_q  <= '0;
			fout_len_q <= '0;
			clip_len_q <= FRAME_W'(1);
			chan_cnt_q <= CHCNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_GAIN:       gain_q     <= cfg_data[GAIN_W-1:0];
				CFG_FADE_IN_FRAMES:  fin_len_q  <= cfg_data[FRAME_W-1:0];
				CFG_FADE_OUT_FRAMES: fout_len_q <= cfg_data[FRAME_W-1:0];
				CFG_CLIP_FRAMES:     clip_len_q <= cfg_data[FRAME_W-1:0];
				CFG_CHANNEL_COUNT:   chan_cnt_q <= cfg_data[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			ch_q    <= '0;
		end else if (in_acc) begin
			if (done_now) begin
				frame_q <= '0;
				ch_q    <= '0;
			end else if (last_chan) begin
				frame_q <= frame_q + 1'b1;
				ch_q    <= '0;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (sample_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			f_q       <= frame_q;
			fin_en_q  <= (fin_len_q != '0) && (frame_q < fin_len_q);
			fo_one_q  <= (fout_len_q == '0) || (frame_q <= fo_start);
			fo_zero_q <= (frame_q >= len_eff);
			done_q    <= done_now;
			neg_q     <= sample_in.source_sample[SAMPLE_W-1];
			mag_q     <= sample_in.source_sample[SAMPLE_W-1]
				? MAG_W'(-sample_in.source_sample) : MAG_W'(sample_in.source_sample);
			mix_q     <= sample_in.mix_sample;
		end
		if (state_q == ST_DIV_IN && div_rsp.done) begin
			fin_q <= fin_en_q ? FACT_W'(div_rsp.quotient) : Q16_ONE;
		end
		if (state_q == ST_DIV_OUT && div_rsp.done) begin
			if (fo_one_q) begin
				fout_q <= Q16_ONE;
			end else if (fo_zero_q) begin
				fout_q <= '0;
			end else begin
				fout_q <= FACT_W'(div_rsp.quotient);
			end
		end
		case (state_q)
			ST_MUL_FADE: p1_q     <= mul_p[P1_W-1:0];
			ST_MUL_GAIN: p2_q     <= mul_p[P2_W-1:0];
			ST_MUL_LO:   acc_q    <= mul_p[MUL_A_W+15:16];
			ST_MUL_HI:   scaled_q <= hi_sum[SCALED_W+27:28];
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) begin
			res_q      <= sat_w;
			res_done_q <= done_q;
		end
	end

	// hold the pending sum between the add cycle and the output load
	logic signed [SAMPLE_W-1:0] sat_s1;
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			sat_s1 <= sat_w;
		end
	end

	assign sample_out.valid        = ov_q;
	assign sample_out.mixed_sample = res_q;
	assign sample_out.clip_done    = res_done_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_OUT)
		else $error("result word raised outside the output load");

	assert property (@(posedge clk) disable iff (!arst_n)
		CHE_W'(ch_q) < MAX_CH)
		else $error("channel counter past channel limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL_FADE |-> (fin_q <= Q16_ONE) && (fout_q <= Q16_ONE))
		else $error("fade factor above unity");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> $past(state_q) == ST_SUM || sat_s1 == sat_w)
		else $error("sum changed while waiting for the output register");

endmodule
